// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; builds may compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked property with an active-low reset disable.
`define ASSERT_CLKRST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Clocked property without any disable condition.
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLKRST(lbl, clk, rstn, prop)
`define ASSERT_CLK(lbl, clk, prop)

`endif

`endif

// ----- sv/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// Tokenizer package
// Token kinds, byte constants, result type and byte classification helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    localparam int unsigned POSITION_BITS_DEFAULT = 16;

    // Token kind codes reported on the result port.
    localparam logic [4:0] KIND_LABEL        = 5'd0;
    localparam logic [4:0] KIND_STRING       = 5'd1;
    localparam logic [4:0] KIND_INTEGER      = 5'd2;
    localparam logic [4:0] KIND_NONE         = 5'd0;
    localparam logic [4:0] KIND_UNTERMINATED = 5'd18;

    // Special byte values.
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_FF         = 8'hFF;

    // One reported token, with its last-of-byte mark.
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } result_t;

    function automatic logic is_dec_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_label_head(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
            || (b == CH_UNDERSCORE);
    endfunction

    function automatic logic is_label_body(input logic [7:0] b);
        return is_label_head(b) || is_dec_digit(b);
    endfunction

    // Punctuation kind, or KIND_NONE for any other byte.
    function automatic logic [4:0] punct_kind(input logic [7:0] b);
        logic [4:0] k;
        unique case (b)
            8'h3B:   k = 5'd3;   // ;
            8'h3A:   k = 5'd4;   // :
            8'h28:   k = 5'd5;   // (
            8'h29:   k = 5'd6;   // )
            8'h5B:   k = 5'd7;   // [
            8'h5D:   k = 5'd8;   // ]
            8'h7B:   k = 5'd9;   // {
            8'h7D:   k = 5'd10;  // }
            8'h2A:   k = 5'd11;  // *
            8'h3D:   k = 5'd12;  // =
            8'h2C:   k = 5'd13;  // ,
            8'h2D:   k = 5'd14;  // -
            8'h3E:   k = 5'd15;  // >
            8'h3C:   k = 5'd16;  // <
            8'h2E:   k = 5'd17;  // .
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- sv/stt_core.sv -----
// ----------------------------------------------------------------------------
// Tokenizer core
// Holds the open-token state and turns one byte into up to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_core #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [7:0]        text_byte,
    input  wire logic              end_of_text,
    output logic [1:0]             res_count,
    output stt_pkg::result_t       res0,
    output stt_pkg::result_t       res1
);
    import stt_pkg::*;

    localparam int unsigned PB = POSITION_BITS;
    localparam logic [PB-1:0] POS_ZERO = '0;
    localparam logic [PB-1:0] POS_ONE  = PB'(1);

    // Open-token codes.
    localparam logic [1:0] OPEN_NONE   = 2'd0;
    localparam logic [1:0] OPEN_LABEL  = 2'd1;
    localparam logic [1:0] OPEN_STRING = 2'd2;
    localparam logic [1:0] OPEN_INT    = 2'd3;

    logic [1:0]    open_kind_reg, open_kind_next;
    logic [PB-1:0] open_start_reg, open_start_next;
    logic [PB-1:0] byte_pos_reg, byte_pos_next;
    logic          prior_bs_reg, prior_bs_next;
    logic          after_term_reg, after_term_next;

    // Leading token (flush or string close) and trailing token (punct or end flush).
    logic          p_valid, q_valid, taken;
    logic [4:0]    p_kind, q_kind, punct;
    logic [PB-1:0] p_start, q_start, p_len, q_len;
    logic [31:0]   p_start_w, q_start_w, p_len_w, q_len_w;

    // Step logic for one byte.
    always_comb begin
        open_kind_next  = open_kind_reg;
        open_start_next = open_start_reg;
        prior_bs_next   = prior_bs_reg;
        after_term_next = after_term_reg;
        byte_pos_next   = byte_pos_reg + POS_ONE;
        taken   = 1'b0;
        p_valid = 1'b0;
        p_kind  = KIND_NONE;
        p_start = open_start_reg;
        p_len   = byte_pos_reg - open_start_reg;
        q_valid = 1'b0;
        q_kind  = KIND_NONE;
        q_start = byte_pos_reg;
        q_len   = POS_ONE;
        punct   = punct_kind(text_byte);

        if (!after_term_reg) begin
            if ((text_byte == CH_NUL) || (text_byte == CH_FF)) begin
                // Terminator: flush whatever is open and ignore bytes until end.
                p_valid = (open_kind_reg != OPEN_NONE);
                p_kind  = (open_kind_reg == OPEN_STRING) ? KIND_UNTERMINATED
                        : ((open_kind_reg == OPEN_LABEL) ? KIND_LABEL : KIND_INTEGER);
                open_kind_next  = OPEN_NONE;
                prior_bs_next   = 1'b0;
                after_term_next = 1'b1;
            end else begin
                // Continue or close the open token.
                unique case (open_kind_reg)
                    OPEN_STRING: begin
                        taken = 1'b1;
                        if ((text_byte == CH_QUOTE) && !prior_bs_reg) begin
                            p_valid        = 1'b1;
                            p_kind         = KIND_STRING;
                            p_len          = byte_pos_reg + POS_ONE - open_start_reg;
                            open_kind_next = OPEN_NONE;
                            prior_bs_next  = 1'b0;
                        end else begin
                            prior_bs_next = (text_byte == CH_BACKSLASH);
                        end
                    end
                    OPEN_LABEL: begin
                        if (is_label_body(text_byte)) begin
                            taken = 1'b1;
                        end else begin
                            p_valid        = 1'b1;
                            p_kind         = KIND_LABEL;
                            open_kind_next = OPEN_NONE;
                            prior_bs_next  = 1'b0;
                        end
                    end
                    OPEN_INT: begin
                        if (is_dec_digit(text_byte)) begin
                            taken = 1'b1;
                        end else begin
                            p_valid        = 1'b1;
                            p_kind         = KIND_INTEGER;
                            open_kind_next = OPEN_NONE;
                            prior_bs_next  = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase

                // Start a new token or report a punctuation byte.
                if (!taken) begin
                    priority if (is_label_head(text_byte)) begin
                        open_kind_next  = OPEN_LABEL;
                        open_start_next = byte_pos_reg;
                    end else if (text_byte == CH_QUOTE) begin
                        open_kind_next  = OPEN_STRING;
                        open_start_next = byte_pos_reg;
                        prior_bs_next   = 1'b0;
                    end else if (is_dec_digit(text_byte)) begin
                        open_kind_next  = OPEN_INT;
                        open_start_next = byte_pos_reg;
                    end else if (punct != KIND_NONE) begin
                        q_valid = 1'b1;
                        q_kind  = punct;
                    end else begin
                    end
                end

                // End of text flushes the token including this byte.
                if (end_of_text && (open_kind_next != OPEN_NONE)) begin
                    q_valid = 1'b1;
                    q_kind  = (open_kind_next == OPEN_STRING) ? KIND_UNTERMINATED
                            : ((open_kind_next == OPEN_LABEL) ? KIND_LABEL : KIND_INTEGER);
                    q_start = open_start_next;
                    q_len   = byte_pos_reg + POS_ONE - open_start_next;
                end
            end
        end

        // End of text restarts positions and accepts bytes again.
        if (end_of_text) begin
            open_kind_next  = OPEN_NONE;
            open_start_next = POS_ZERO;
            byte_pos_next   = POS_ZERO;
            prior_bs_next   = 1'b0;
            after_term_next = 1'b0;
        end
    end

    // Cut positions and lengths to the 16-bit result fields.
    assign p_start_w = 32'(p_start);
    assign q_start_w = 32'(q_start);
    assign p_len_w   = 32'(p_len);
    assign q_len_w   = 32'(q_len);

    // Pack the tokens in order; the final one carries the last mark.
    always_comb begin
        res_count = {1'b0, p_valid} + {1'b0, q_valid};
        if (p_valid) begin
            res0 = '{kind: p_kind, start: p_start_w[15:0], length: p_len_w[15:0],
                     last: !q_valid};
        end else begin
            res0 = '{kind: q_kind, start: q_start_w[15:0], length: q_len_w[15:0],
                     last: 1'b1};
        end
        res1 = '{kind: q_kind, start: q_start_w[15:0], length: q_len_w[15:0],
                 last: 1'b1};
    end

    // State registers advance once per consumed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_kind_reg  <= OPEN_NONE;
            open_start_reg <= POS_ZERO;
            byte_pos_reg   <= POS_ZERO;
            prior_bs_reg   <= 1'b0;
            after_term_reg <= 1'b0;
        end else if (step) begin
            open_kind_reg  <= open_kind_next;
            open_start_reg <= open_start_next;
            byte_pos_reg   <= byte_pos_next;
            prior_bs_reg   <= prior_bs_next;
            after_term_reg <= after_term_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/stt_result_buf.sv -----
// ----------------------------------------------------------------------------
// Tokenizer result buffer
// Two-entry output register that hands out tokens one transfer at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_result_buf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire logic [1:0]        load_count,
    input  wire stt_pkg::result_t  load0,
    input  wire stt_pkg::result_t  load1,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output stt_pkg::result_t       head,
    output logic                   free,
    output logic [1:0]             count
);
    import stt_pkg::*;

    logic [1:0] count_reg, count_next;
    result_t    ent0_reg, ent0_next;
    result_t    ent1_reg, ent1_next;
    logic       pop;

    assign m_tvalid = (count_reg != 2'd0);
    assign head     = ent0_reg;
    assign count    = count_reg;
    assign pop      = m_tvalid && m_tready;
    // A new pair may land once the register is empty, or holds one entry that leaves now.
    assign free     = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_tready);

    // Next contents: load replaces, otherwise a transfer shifts down.
    always_comb begin
        count_next = count_reg;
        ent0_next  = ent0_reg;
        ent1_next  = ent1_reg;
        if (load) begin
            count_next = load_count;
            ent0_next  = load0;
            ent1_next  = load1;
        end else if (pop) begin
            count_next = count_reg - 2'd1;
            ent0_next  = ent1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

endmodule

`default_nettype wire

// ----- sv/source_text_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// Source text tokenizer
// Streaming lexer: one text byte per input transfer, one token per output.
// ----------------------------------------------------------------------------
// A byte enters an input register, is classified against the open token in
// one pass, and its tokens are registered in a two-entry output register,
// from which the first token can then be transferred. The block takes one
// byte per cycle as long as each byte yields at most one token and the output
// is ready; a byte that yields two tokens holds the input while both are
// buffered, since the output register drains one token per transfer.
// Token text is not carried: a token is its kind, its start offset within
// the text and its length, and tlast on the input resets the offsets for the
// next text.
`default_nettype none

`include "assert_macros.svh"

module source_text_tokenizer_unit #(
    parameter int unsigned POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [4:0] token_kind, [20:5] token_start,
                                        // [36:21] token_length, [39:37] zero
    output logic             m_tlast    // last_of_run
);
    import stt_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eot_reg;
    logic       consume, free, s_xfer;
    logic [1:0] res_count, buf_count;
    result_t    res0, res1, head;

    // Input register: refilled whenever it is empty or being consumed.
    assign consume  = in_valid_reg && free;
    assign s_tready = !in_valid_reg || free;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    // Classification and open-token state.
    stt_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (consume),
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .res_count   (res_count),
        .res0        (res0),
        .res1        (res1)
    );

    // Output register for the tokens of one byte.
    stt_result_buf u_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (consume),
        .load_count (res_count),
        .load0      (res0),
        .load1      (res1),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .head       (head),
        .free       (free),
        .count      (buf_count)
    );

    assign m_tdata = {3'b000, head.length, head.start, head.kind};
    assign m_tlast = head.last;

    // With two tokens buffered the front one is never the last of its byte.
    `ASSERT_CLKRST(a_pair_head_not_last, aclk, aresetn, (buf_count == 2'd2) |-> !m_tlast)
    // An empty input register always takes a transfer.
    `ASSERT_CLKRST(a_empty_input_ready, aclk, aresetn, !in_valid_reg |-> s_tready)
    // Reported kinds stay within the defined codes.
    `ASSERT_CLKRST(a_kind_range, aclk, aresetn, m_tvalid |-> (m_tdata[4:0] <= KIND_UNTERMINATED))

endmodule

`default_nettype wire
